/* sv/prc_pkg.sv */
// Types and constants shared by the pump reverse-clean sequencer.
// No dependencies; used by prc_step and pump_reverse_clean_sequencer_core.
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

    // Number of hold ticks after each speed target is reached
    localparam logic [1:0] HOLD_TICKS = 2'd2;

    // Reciprocal of five for a 16-bit dividend: x / 5 == (x * RECIP5) >> RECIP5_SHIFT
    localparam logic [16:0] RECIP5       = 17'd52429;
    localparam int          RECIP5_SHIFT = 18;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_REVERSE_CYCLES = 2'd0;
    localparam logic [1:0] REG_REVERSE_SPEED  = 2'd1;
    localparam logic [1:0] REG_RAMP_SETTING   = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_RUNNING = 2'd0;
    localparam logic [1:0] STATUS_DONE    = 2'd1;
    localparam logic [1:0] STATUS_BAD_CFG = 2'd2;

    // Control-loop delay codes
    localparam logic [1:0] DELAY_KEEP  = 2'd0;
    localparam logic [1:0] DELAY_SHORT = 2'd1;
    localparam logic [1:0] DELAY_LONG  = 2'd2;

    // Sequencer phases
    typedef enum logic [4:0] {
        PH_CHECK = 5'b00001,
        PH_DECEL = 5'b00010,
        PH_STOP  = 5'b00100,
        PH_ACCEL = 5'b01000,
        PH_RUN   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [15:0] reverse_cycles;
        logic [14:0] reverse_speed;
        logic [15:0] ramp_setting;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] cycles_left;
        logic [1:0]  hold_ticks;
    } seq_state_t;

    typedef struct packed {
        logic               restart;
        logic signed [15:0] motor_freq;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               speed_cmd_valid;
        logic signed [15:0] speed_cmd;
        logic               ramp_valid;
        logic [13:0]        ramp_time;
        logic [1:0]         delay_code;
    } out_item_t;

endpackage

`default_nettype wire

/* sv/pump_reverse_clean_sequencer_core.sv */
// Top level of the pump reverse-clean sequencer: config registers, input
// register, sequencer state and result register. Depends on prc_pkg, prc_step.
//
//   channel  | direction | ports                        | payload
//   ---------+-----------+------------------------------+--------------------
//   input    | in        | s_valid, s_ready, s_data     | prc_pkg::in_item_t
//   result   | out       | m_valid, m_ready, m_data     | prc_pkg::out_item_t
//   config   | in        | cfg_wr_en, cfg_index, cfg_wr_data | 16-bit write data
//
// One item per clock sustained while m_ready accepts results; each item yields exactly one result item.
// An item passes through the input register, then one step of the sequencer
// logic into the result register.
// aresetn is synchronous, active low; it clears configuration and state.
// A stalled result holds the step; the input register still takes one item.
`timescale 1ns / 1ps
`default_nettype none

module pump_reverse_clean_sequencer_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire prc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output prc_pkg::out_item_t  m_data,
    input  wire                 cfg_wr_en,
    input  wire [1:0]           cfg_index,
    input  wire [15:0]          cfg_wr_data
);

    prc_pkg::cfg_t       cfg_reg;
    prc_pkg::seq_state_t state_reg;
    prc_pkg::seq_state_t state_next;
    prc_pkg::in_item_t   in_data_reg;
    logic                in_valid_reg;
    prc_pkg::out_item_t  out_data_reg;
    logic                out_valid_reg;
    prc_pkg::out_item_t  step_result;
    logic                advance;

    // Move the held item into the result register when that register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                prc_pkg::REG_REVERSE_CYCLES: cfg_reg.reverse_cycles <= cfg_wr_data;
                prc_pkg::REG_REVERSE_SPEED:  cfg_reg.reverse_speed  <= cfg_wr_data[14:0];
                prc_pkg::REG_RAMP_SETTING:   cfg_reg.ramp_setting   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    prc_step u_step (
        .item       (in_data_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Hold the input payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= prc_pkg::PH_CHECK;
            state_reg.cycles_left <= '0;
            state_reg.hold_ticks  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    // A restart item always returns the sequencer to the check
    a_restart_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.restart |=> state_reg.phase == prc_pkg::PH_CHECK)
        else $error("restart did not return to configuration check");

    // Ramp times are only issued together with the short loop delay
    a_ramp_with_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ramp_valid |-> m_data.delay_code == prc_pkg::DELAY_SHORT)
        else $error("ramp issued without short loop delay");

    // Speed value is zero unless a command is issued
    a_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.speed_cmd_valid |-> m_data.speed_cmd == 16'sd0)
        else $error("speed value set without a command");

    // The cycle count only drops when a reverse command goes out
    a_cycle_use: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && state_reg.phase == prc_pkg::PH_STOP
            && state_next.cycles_left != state_reg.cycles_left
        |=> m_data.speed_cmd_valid && m_data.delay_code == prc_pkg::DELAY_SHORT)
        else $error("cycle used without reverse command");

endmodule

`default_nettype wire

/* sv/prc_step.sv */
// One sequencer step: next state and result item from the current item.
// Depends on prc_pkg for the item, state and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module prc_step (
    input  wire prc_pkg::in_item_t   item,
    input  wire prc_pkg::cfg_t       cfg,
    input  wire prc_pkg::seq_state_t state_cur,
    output prc_pkg::seq_state_t      state_next,
    output prc_pkg::out_item_t       result
);

    logic [32:0]        ramp_prod;
    logic [13:0]        ramp_div5;
    logic [15:0]        neg_speed;
    logic signed [16:0] freq_plus_speed;
    logic               cfg_ok;
    logic               freq_nonneg;
    logic               freq_reached;

    // Divide the ramp setting by five through the reciprocal
    assign ramp_prod = {1'b0, cfg.ramp_setting} * {16'd0, prc_pkg::RECIP5};
    assign ramp_div5 = ramp_prod[prc_pkg::RECIP5_SHIFT +: 14];

    // Reverse command and frequency tests
    assign neg_speed       = 16'd0 - {1'b0, cfg.reverse_speed};
    assign freq_plus_speed = $signed({item.motor_freq[15], item.motor_freq})
                           + $signed({2'b00, cfg.reverse_speed});
    assign freq_nonneg     = ~item.motor_freq[15];
    assign freq_reached    = freq_plus_speed[16] || (freq_plus_speed == 17'sd0);
    assign cfg_ok          = (cfg.reverse_cycles != 16'd0) && (cfg.reverse_speed != 15'd0)
                          && (cfg.ramp_setting != 16'd0);

    // Advance the phase and build the result
    always_comb begin
        state_next = state_cur;
        result     = '0;
        if (item.restart) begin
            state_next.phase = prc_pkg::PH_CHECK;
        end else begin
            case (state_cur.phase)
                prc_pkg::PH_CHECK: begin
                    if (cfg_ok) begin
                        result.ramp_valid      = 1'b1;
                        result.ramp_time       = ramp_div5;
                        result.delay_code      = prc_pkg::DELAY_SHORT;
                        state_next.cycles_left = cfg.reverse_cycles;
                        state_next.phase       = prc_pkg::PH_DECEL;
                    end else begin
                        result.status = prc_pkg::STATUS_BAD_CFG;
                    end
                end
                prc_pkg::PH_DECEL: begin
                    result.speed_cmd_valid = 1'b1;
                    if (freq_nonneg) begin
                        state_next.phase      = prc_pkg::PH_STOP;
                        state_next.hold_ticks = prc_pkg::HOLD_TICKS;
                        result.delay_code     = prc_pkg::DELAY_LONG;
                    end
                end
                prc_pkg::PH_STOP: begin
                    if (state_cur.hold_ticks == 2'd0) begin
                        if (state_cur.cycles_left == 16'd0) begin
                            result.status = prc_pkg::STATUS_DONE;
                        end else begin
                            state_next.cycles_left = state_cur.cycles_left - 16'd1;
                            result.speed_cmd_valid = 1'b1;
                            result.speed_cmd       = neg_speed;
                            result.delay_code      = prc_pkg::DELAY_SHORT;
                            state_next.phase       = prc_pkg::PH_ACCEL;
                        end
                    end else begin
                        state_next.hold_ticks = state_cur.hold_ticks - 2'd1;
                    end
                end
                prc_pkg::PH_ACCEL: begin
                    if (freq_reached) begin
                        state_next.hold_ticks = prc_pkg::HOLD_TICKS;
                        result.delay_code     = prc_pkg::DELAY_LONG;
                        state_next.phase      = prc_pkg::PH_RUN;
                    end
                end
                prc_pkg::PH_RUN: begin
                    if (state_cur.hold_ticks == 2'd0) begin
                        result.speed_cmd_valid = 1'b1;
                        result.speed_cmd       = neg_speed;
                        result.delay_code      = prc_pkg::DELAY_SHORT;
                        state_next.phase       = prc_pkg::PH_DECEL;
                    end else begin
                        state_next.hold_ticks = state_cur.hold_ticks - 2'd1;
                    end
                end
                default: begin
                    state_next.phase = prc_pkg::PH_CHECK;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
